// ===== design/dwt_pkg.sv =====
package dwt_pkg;

    localparam int SLOTS        = 32;
    localparam int TASK_ID_BITS = 8;
    localparam int DL_W         = 64;
    localparam int WORD_W       = TASK_ID_BITS + DL_W;
    localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W        = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ACT_ARM    = 2'd0,
        ACT_DISARM = 2'd1,
        ACT_TICK   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_ARM      = 2'd0,
        KIND_DISARM   = 2'd1,
        KIND_EXPIRED  = 2'd2,
        KIND_TICK_END = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef enum logic {
        CMP_TASK,
        CMP_TIME
    } t_cmp_mode;

    typedef struct packed {
        t_cmp_mode        mode;
        logic [DL_W-1:0]  key;
    } t_cmp_req;

endpackage

// ===== design/dwt_ram.sv =====
module dwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dwt_cmp.sv =====
module dwt_cmp (
    input  dwt_pkg::t_cmp_req                    i_req,
    input  logic [dwt_pkg::TASK_ID_BITS-1:0]     i_rd_task,
    input  logic [dwt_pkg::DL_W-1:0]             i_rd_deadline,
    output logic                                 o_hit
);
    import dwt_pkg::*;

    logic [DL_W-1:0] lhs;

    // one comparator: task match by equality, expiry by deadline <= now
    always_comb begin
        lhs   = (i_req.mode == CMP_TASK) ? DL_W'(i_rd_task) : i_rd_deadline;
        o_hit = (i_req.mode == CMP_TASK) ? (lhs == i_req.key) : (lhs <= i_req.key);
    end

endmodule

// ===== design/deadline_wake_table_unit.sv =====
// Deadline wake table: a table of SLOTS task wake deadlines.
// Input channel (i_in_valid / o_in_ready) takes one word: an action, a task
// id, a deadline and the current time. Arm replaces the deadline of the
// task's armed entry or claims the lowest free entry; disarm frees the
// task's entry; tick reports every armed entry whose deadline is at or
// before the current time, in ascending entry order, frees each one, and
// closes with a tick-end word. Action code 3 is taken and dropped.
// Output channel (o_out_valid / i_out_ready) carries kind, status, woken
// task and last; last marks the final word of an input.
// Timing: one entry is read from the table RAM and checked by the shared
// comparator per cycle, unless a tick scan holds for the output register;
// arm or disarm stops at the first match, and a null arm or disarm skips
// the scan. o_in_ready is high only while no item is in work; a
// finished word may wait in the output register while the next item is
// taken. When the receiver stalls, a tick scan holds on the expired entry
// until the output register frees up. Reset (i_rst_n low, synchronous)
// clears all armed bits and the control state; no clearing pass is needed.
module deadline_wake_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_task_id,
    input  logic [63:0] i_deadline,
    input  logic [63:0] i_current_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_woken_task,
    output logic        o_last
);
    import dwt_pkg::*;

    t_state                  r_state, n_state;
    t_action                 r_action;
    logic [TASK_ID_BITS-1:0] r_task;
    logic [DL_W-1:0]         r_word;
    logic [CNT_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_eidx;
    logic                    r_dv;
    logic [SLOTS-1:0]        r_armed;
    logic                    r_found;
    logic                    r_free_ok;
    logic [IDX_W-1:0]        r_free_idx;

    logic                    r_ov;
    t_kind                   r_kind;
    t_status                 r_status;
    logic [7:0]              r_woken;
    logic                    r_last;

    logic [TASK_ID_BITS-1:0] in_task;
    logic                    in_fire;
    logic                    out_free;
    logic [WORD_W-1:0]       rdata;
    logic [TASK_ID_BITS-1:0] rd_task;
    logic [DL_W-1:0]         rd_dl;
    t_cmp_req                cmp_req;
    logic                    hit;
    logic                    cand;
    logic                    at_end;

    logic                    stall;
    logic                    consume;
    logic                    stop;
    logic                    adv;
    logic                    emit;
    logic                    clr;
    logic                    scan_done;
    logic                    fin;
    logic                    new_write;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    t_kind                   fin_kind;
    t_status                 fin_status;

    assign in_task    = TASK_ID_BITS'(i_task_id);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_ov || i_out_ready;

    assign rd_task = rdata[WORD_W-1 -: TASK_ID_BITS];
    assign rd_dl   = rdata[DL_W-1:0];
    assign at_end  = (r_idx == CNT_W'(SLOTS));

    always_comb begin
        cmp_req.mode = (r_action == ACT_TICK) ? CMP_TIME : CMP_TASK;
        cmp_req.key  = (r_action == ACT_TICK) ? r_word : DL_W'(r_task);
    end

    dwt_cmp u_cmp (
        .i_req         (cmp_req),
        .i_rd_task     (rd_task),
        .i_rd_deadline (rd_dl),
        .o_hit         (hit)
    );

    assign cand = r_dv && r_armed[r_eidx] && hit;

    dwt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_task, r_word}),
        .i_re    (adv),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // sequencer outputs
    always_comb begin
        stall      = 1'b0;
        consume    = 1'b0;
        stop       = 1'b0;
        adv        = 1'b0;
        emit       = 1'b0;
        clr        = 1'b0;
        scan_done  = 1'b0;
        fin        = 1'b0;
        new_write  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_eidx;
        fin_kind   = KIND_ARM;
        fin_status = ST_OK;
        case (r_state)
            S_SCAN: begin
                // hold on an expired entry until the output register is free
                stall     = (r_action == ACT_TICK) && cand && !out_free;
                consume   = r_dv && !stall;
                stop      = consume && cand && (r_action != ACT_TICK);
                adv       = !at_end && !stall && !stop;
                emit      = consume && cand && (r_action == ACT_TICK);
                clr       = consume && cand && (r_action != ACT_ARM);
                ram_we    = stop && (r_action == ACT_ARM);
                scan_done = stop || (at_end && (!r_dv || consume));
            end
            S_DONE: begin
                fin = out_free;
                case (r_action)
                    ACT_ARM: begin
                        fin_kind = KIND_ARM;
                        if (r_task == '0) begin
                            fin_status = ST_NULL;
                        end else if (r_found || r_free_ok) begin
                            fin_status = ST_OK;
                        end else begin
                            fin_status = ST_FULL;
                        end
                        new_write = fin && (r_task != '0) && !r_found && r_free_ok;
                    end
                    ACT_DISARM: fin_kind = KIND_DISARM;
                    default:    fin_kind = KIND_TICK_END;
                endcase
                ram_we    = new_write;
                ram_waddr = r_free_idx;
            end
            default: begin
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (t_action'(i_action))
                        ACT_ARM, ACT_DISARM: begin
                            n_state = (in_task == '0) ? S_DONE : S_SCAN;
                        end
                        ACT_TICK: n_state = S_SCAN;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dv      <= 1'b0;
            r_idx     <= '0;
            r_armed   <= '0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_fire) begin
                r_dv      <= 1'b0;
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
            end else if (adv) begin
                r_dv  <= 1'b1;
                r_idx <= r_idx + CNT_W'(1);
            end else if (consume) begin
                r_dv <= 1'b0;
            end

            if (stop && (r_action == ACT_ARM)) begin
                r_found <= 1'b1;
            end
            // remember the lowest free entry seen in an arm scan
            if (consume && (r_action == ACT_ARM) && !r_armed[r_eidx] && !r_free_ok) begin
                r_free_ok <= 1'b1;
            end

            if (clr || emit) begin
                r_armed[r_eidx] <= 1'b0;
            end
            if (new_write) begin
                r_armed[r_free_idx] <= 1'b1;
            end

            if (emit || fin) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= t_action'(i_action);
            r_task   <= in_task;
            r_word   <= (t_action'(i_action) == ACT_TICK) ? i_current_time : i_deadline;
        end
        if (adv) begin
            r_eidx <= r_idx[IDX_W-1:0];
        end
        if (consume && (r_action == ACT_ARM) && !r_armed[r_eidx] && !r_free_ok) begin
            r_free_idx <= r_eidx;
        end
        if (emit) begin
            r_kind   <= KIND_EXPIRED;
            r_status <= ST_OK;
            r_woken  <= 8'(rd_task);
            r_last   <= 1'b0;
        end else if (fin) begin
            r_kind   <= fin_kind;
            r_status <= fin_status;
            r_woken  <= '0;
            r_last   <= 1'b1;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_kind       = r_kind;
    assign o_status     = r_status;
    assign o_woken_task = r_woken;
    assign o_last       = r_last;

    a_dv_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SCAN))
        else $error("table read pending outside a scan");

    a_write_only_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_action == ACT_ARM))
        else $error("table written by a non-arm item");

    a_claim_sets_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        new_write |=> r_armed[$past(r_free_idx)])
        else $error("claimed entry not armed");

    a_expire_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> !r_armed[$past(r_eidx)])
        else $error("expired entry still armed");

    a_expired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_EXPIRED)) |-> !o_last)
        else $error("expired-task word flagged last");

endmodule
